// ===== design/cpet_pkg.sv =====
package cpet_pkg;

    localparam int GROUP_W   = 3;
    localparam int MASK_BITS = 64;
    localparam int MASK_ROW  = 8;
    localparam int EVENT_W   = 3;

    typedef logic [EVENT_W-1:0] t_event;

    localparam t_event EV_SKIP  = 3'd0;
    localparam t_event EV_ENTER = 3'd1;
    localparam t_event EV_STAY  = 3'd2;
    localparam t_event EV_EXIT  = 3'd3;
    localparam t_event EV_APART = 3'd4;

    typedef struct packed {
        t_event ev;
        logic   ovl;
        logic   full;
    } t_result;

endpackage

// ===== design/collision_pair_event_tracker.sv =====
// Collision pair event tracker.
// Command channel: a pair word is taken on a clock edge with i_start high and
// o_busy low. Each taken word gives exactly one result word on o_event_res,
// o_overlapping and o_table_full, shown for one cycle with o_strobe high; the
// receiver cannot stall, so results are never held back.
// Config channel: i_cfg_valid / o_cfg_ready write the 64-bit group-pair
// enable mask; ready is always high. Write it only while the block is idle.
// The front registers and classifies a word (group order, mask, equal ids,
// box overlap) and places it in a two-entry queue; the back searches the pair
// table, one RAM holding key and touching flag per entry.
// Timing: a word passes the front register and the queue, and the back
// registers its result. Skipped words and the first stored pair need no table
// read; any other word goes through a linear table scan, a RAM read (S_READ)
// and a compare (S_CMP) per entry, up to a hit or the last of the n stored
// pairs (n up to PAIR_ENTRIES). The back takes a queued word only in S_IDLE,
// so it finishes one word before it takes the next; the front takes a word per
// cycle until its register and the queue are full, then holds o_busy high.
// Reset: clears the mask, the queue and the fill count; the table needs no
// clearing pass since only entries below the fill count are read.
module collision_pair_event_tracker #(
    parameter int PAIR_ENTRIES = 64,
    parameter int GROUPS       = 8,
    parameter int ID_BITS      = 32,
    parameter int COORD_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cpet_pkg::MASK_BITS-1:0] i_cfg_data,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [cpet_pkg::GROUP_W-1:0]   i_left_group,
    input  logic [cpet_pkg::GROUP_W-1:0]   i_right_group,
    input  logic [ID_BITS-1:0]             i_left_id,
    input  logic [ID_BITS-1:0]             i_right_id,
    input  logic signed [COORD_BITS-1:0]   i_left_x,
    input  logic signed [COORD_BITS-1:0]   i_left_y,
    input  logic [COORD_BITS-1:0]          i_left_w,
    input  logic [COORD_BITS-1:0]          i_left_h,
    input  logic signed [COORD_BITS-1:0]   i_right_x,
    input  logic signed [COORD_BITS-1:0]   i_right_y,
    input  logic [COORD_BITS-1:0]          i_right_w,
    input  logic [COORD_BITS-1:0]          i_right_h,
    output logic                           o_strobe,
    output logic [cpet_pkg::EVENT_W-1:0]   o_event_res,
    output logic                           o_overlapping,
    output logic                           o_table_full
);

    localparam int QW = 2 * ID_BITS + 2;

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;
    cpet_pkg::t_result result;

    cpet_front #(
        .GROUPS     (GROUPS),
        .ID_BITS    (ID_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_left_group  (i_left_group),
        .i_right_group (i_right_group),
        .i_left_id     (i_left_id),
        .i_right_id    (i_right_id),
        .i_left_x      (i_left_x),
        .i_left_y      (i_left_y),
        .i_left_w      (i_left_w),
        .i_left_h      (i_left_h),
        .i_right_x     (i_right_x),
        .i_right_y     (i_right_y),
        .i_right_w     (i_right_w),
        .i_right_h     (i_right_h),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    cpet_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    cpet_back #(
        .PAIR_ENTRIES (PAIR_ENTRIES),
        .ID_BITS      (ID_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_strobe  (o_strobe),
        .o_result  (result)
    );

    assign o_event_res   = result.ev;
    assign o_overlapping = result.ovl;
    assign o_table_full  = result.full;

endmodule

// ===== design/cpet_ram.sv =====
module cpet_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cpet_front.sv =====
module cpet_front #(
    parameter int GROUPS     = 8,
    parameter int ID_BITS    = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cpet_pkg::MASK_BITS-1:0]   i_cfg_data,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [cpet_pkg::GROUP_W-1:0]     i_left_group,
    input  logic [cpet_pkg::GROUP_W-1:0]     i_right_group,
    input  logic [ID_BITS-1:0]               i_left_id,
    input  logic [ID_BITS-1:0]               i_right_id,
    input  logic signed [COORD_BITS-1:0]     i_left_x,
    input  logic signed [COORD_BITS-1:0]     i_left_y,
    input  logic [COORD_BITS-1:0]            i_left_w,
    input  logic [COORD_BITS-1:0]            i_left_h,
    input  logic signed [COORD_BITS-1:0]     i_right_x,
    input  logic signed [COORD_BITS-1:0]     i_right_y,
    input  logic [COORD_BITS-1:0]            i_right_w,
    input  logic [COORD_BITS-1:0]            i_right_h,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output logic [2*ID_BITS+1:0]             o_q_data
);

    localparam int C = COORD_BITS;

    logic [cpet_pkg::MASK_BITS-1:0] r_mask;
    logic                           r_s1_valid;
    logic                           r_s1_skip;
    logic [2*ID_BITS-1:0]           r_s1_key;
    logic signed [C-1:0]            r_lp [2];
    logic signed [C-1:0]            r_rp [2];
    logic [C-1:0]                   r_ls [2];
    logic [C-1:0]                   r_rs [2];

    logic                           accept;
    logic                           swap;
    logic [cpet_pkg::GROUP_W-1:0]   row;
    logic [cpet_pkg::GROUP_W-1:0]   col;
    logic                           n_skip;
    logic [1:0]                     axis_ok;
    logic                           ovl;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;
    assign o_busy      = r_s1_valid && i_q_full;
    assign o_q_push    = r_s1_valid && !i_q_full;

    assign swap = i_left_group > i_right_group;
    assign row  = swap ? i_right_group : i_left_group;
    assign col  = swap ? i_left_group : i_right_group;

    always_comb begin
        n_skip = 1'b0;
        if (32'(row) >= GROUPS || 32'(col) >= GROUPS) begin
            n_skip = 1'b1;
        end else if (!r_mask[{row, col}]) begin
            n_skip = 1'b1;
        end else if (i_left_id == i_right_id) begin
            n_skip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (o_q_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_skip <= n_skip;
            r_s1_key  <= swap ? {i_right_id, i_left_id} : {i_left_id, i_right_id};
            r_lp[0]   <= swap ? i_right_x : i_left_x;
            r_lp[1]   <= swap ? i_right_y : i_left_y;
            r_ls[0]   <= swap ? i_right_w : i_left_w;
            r_ls[1]   <= swap ? i_right_h : i_left_h;
            r_rp[0]   <= swap ? i_left_x : i_right_x;
            r_rp[1]   <= swap ? i_left_y : i_right_y;
            r_rs[0]   <= swap ? i_left_w : i_right_w;
            r_rs[1]   <= swap ? i_left_h : i_right_h;
        end
    end

    // 2*|dp| < sl + sr per axis
    always_comb begin
        logic signed [C:0] d;
        logic [C:0]        mag;
        logic [C+1:0]      twice;
        logic [C:0]        sum;
        for (int a = 0; a < 2; a++) begin
            d     = (C+1)'(r_lp[a]) - (C+1)'(r_rp[a]);
            mag   = d[C] ? (C+1)'(-d) : (C+1)'(d);
            twice = {mag, 1'b0};
            sum   = {1'b0, r_ls[a]} + {1'b0, r_rs[a]};
            axis_ok[a] = twice < {1'b0, sum};
        end
    end

    assign ovl      = &axis_ok && !r_s1_skip;
    assign o_q_data = {r_s1_skip, ovl, r_s1_key};

endmodule

// ===== design/cpet_queue.sv =====
module cpet_queue #(
    parameter int WIDTH = 66
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/cpet_back.sv =====
module cpet_back #(
    parameter int PAIR_ENTRIES = 64,
    parameter int ID_BITS      = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  logic [2*ID_BITS+1:0]       i_q_data,
    output logic                       o_q_pop,
    output logic                       o_strobe,
    output cpet_pkg::t_result          o_result
);

    localparam int KW    = 2 * ID_BITS;
    localparam int IDX_W = $clog2(PAIR_ENTRIES);
    localparam int CNT_W = $clog2(PAIR_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [KW-1:0]     r_key, n_key;
    logic              r_ovl, n_ovl;
    logic              r_strobe, n_strobe;
    cpet_pkg::t_result r_result, n_result;

    logic              q_skip;
    logic              q_ovl;
    logic [KW-1:0]     q_key;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [KW:0]       wdata;
    logic              re;
    logic [KW:0]       rdata;
    logic              has_room;
    logic              last;

    assign q_skip   = i_q_data[KW+1];
    assign q_ovl    = i_q_data[KW];
    assign q_key    = i_q_data[KW-1:0];
    assign has_room = r_fill < CNT_W'(PAIR_ENTRIES);
    assign last     = CNT_W'(r_idx) + CNT_W'(1) == r_fill;

    cpet_ram #(
        .WIDTH (KW + 1),
        .DEPTH (PAIR_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_fill   = r_fill;
        n_key    = r_key;
        n_ovl    = r_ovl;
        n_strobe = 1'b0;
        n_result = r_result;
        o_q_pop  = 1'b0;
        we       = 1'b0;
        waddr    = r_fill[IDX_W-1:0];
        wdata    = {r_ovl, r_key};
        re       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_key   = q_key;
                    n_ovl   = q_ovl;
                    if (q_skip) begin
                        n_strobe = 1'b1;
                        n_result = '{ev: cpet_pkg::EV_SKIP, ovl: 1'b0, full: 1'b0};
                    end else if (r_fill == '0) begin
                        we       = 1'b1;
                        wdata    = {q_ovl, q_key};
                        n_fill   = r_fill + CNT_W'(1);
                        n_strobe = 1'b1;
                        n_result = '{ev: q_ovl ? cpet_pkg::EV_ENTER : cpet_pkg::EV_APART,
                                     ovl: q_ovl, full: 1'b0};
                    end else begin
                        n_idx   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                re      = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rdata[KW-1:0] == r_key) begin
                    we       = 1'b1;
                    waddr    = r_idx;
                    n_strobe = 1'b1;
                    n_result.ovl  = r_ovl;
                    n_result.full = 1'b0;
                    if (r_ovl) begin
                        n_result.ev = rdata[KW] ? cpet_pkg::EV_STAY : cpet_pkg::EV_ENTER;
                    end else begin
                        n_result.ev = rdata[KW] ? cpet_pkg::EV_EXIT : cpet_pkg::EV_APART;
                    end
                    n_state = S_IDLE;
                end else if (last) begin
                    we       = has_room;
                    n_fill   = has_room ? r_fill + CNT_W'(1) : r_fill;
                    n_strobe = 1'b1;
                    n_result = '{ev: r_ovl ? cpet_pkg::EV_ENTER : cpet_pkg::EV_APART,
                                 ovl: r_ovl, full: !has_room};
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_ovl    <= n_ovl;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
